// ----- sv/vmne_pkg.sv -----
// ----------------------------------------------------------------------------
// vmne_pkg
// Types and constants shared by the vertex map normal estimator.
// ----------------------------------------------------------------------------
package vmne_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int DIM_W      = 11;
   localparam int ADDR_W     = $clog2(3 * MAX_WIDTH);
   localparam int DEPTH      = 3 * MAX_WIDTH;

   localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;

   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   typedef struct packed {
      logic signed [31:0] vertex_x;
      logic signed [31:0] vertex_y;
      logic signed [31:0] vertex_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic               normal_valid;
      logic [COL_W-1:0]   pixel_column;
      logic [ROW_W-1:0]   pixel_row;
      logic               last_in_run;
   } rsp_type;

   typedef struct packed {
      req_type l;
      req_type r;
      req_type u;
      req_type d;
   } nbr_type;

   typedef struct packed {
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
      logic               valid;
   } norm_type;

   typedef struct packed {
      logic done;
      logic busy;
   } unit_stat_type;

endpackage

// ----- sv/vertex_map_normal_estimator_core.sv -----
// ----------------------------------------------------------------------------
// vertex_map_normal_estimator_core
// Surface normals from a raster-order vertex map held in three row stores.
// ----------------------------------------------------------------------------
// Each request is stored in a row store and causes zero to three results.
// A valid result passes four store reads, then the norm unit (shared
// multiplier, normalizing shifts, 31-step square root, three 45-step
// divisions), then the output register; an invalid one ends the unit early.
// A request with no result frees the input once T_NEXT finds nothing pending.
// Synchronous reset clears counters and control; row stores are not cleared.
module vertex_map_normal_estimator_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  vmne_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output vmne_pkg::rsp_type rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import vmne_pkg::*;

   typedef enum logic [4:0] {
      T_IDLE = 5'b00001,
      T_NEXT = 5'b00010,
      T_READ = 5'b00100,
      T_RUN  = 5'b01000,
      T_OUT  = 5'b10000
   } tstate_type;

   tstate_type state_ff, state_in;
   logic [DIM_W-1:0] fw_ff, fw_in, fh_ff, fh_in;
   logic [COL_W-1:0] col_ff, col_in, ccol_ff, ccol_in, ec_ff, ec_in;
   logic [ROW_W-1:0] row_ff, row_in, crow_ff, crow_in, er_ff, er_in;
   logic [1:0] b0_ff, b0_in, b1_ff, b1_in, b2_ff, b2_in;
   logic [1:0] sb0_ff, sb0_in, sb1_ff, sb1_in, sb2_ff, sb2_in;
   logic [1:0] cb_ff, cb_in, ub_ff, ub_in, db_ff, db_in;
   logic [2:0] pend_ff, pend_in;
   logic       last_ff, last_in;
   logic [2:0] rc_ff, rc_in;
   nbr_type    nbr_ff, nbr_in;
   logic       rv_ff, rv_in;
   rsp_type    rsp_ff, rsp_in;

   logic [DIM_W-1:0] w_eff, h_eff;
   logic             accept, wrap, start;
   logic [COL_W-1:0] ac;
   logic [ROW_W-1:0] ar;
   logic [1:0]       eb0;
   logic [DIM_W-1:0] ac_n, ar_n, ec_n;
   logic [COL_W-1:0] cl, cr;
   logic [1:0]       rbank;
   logic [COL_W-1:0] rcol;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic             csr_wr;

   req_type mem [0:DEPTH-1];
   req_type rd_data_ff;

   unit_stat_type ustat;
   norm_type      ures;

   always_comb begin
      w_eff = (fw_ff == '0) ? DIM_W'(1) :
              (fw_ff > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : fw_ff;
      h_eff = (fh_ff == '0) ? DIM_W'(1) :
              (fh_ff > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : fh_ff;
   end

   assign req_stall = (state_ff != T_IDLE);
   assign accept    = req_valid && !req_stall;
   assign wrap      = ({1'b0, col_ff} >= w_eff) || ({1'b0, row_ff} >= h_eff);
   assign ac        = wrap ? '0 : col_ff;
   assign ar        = wrap ? '0 : row_ff;
   assign eb0       = wrap ? 2'd0 : b0_ff;
   assign ac_n      = DIM_W'(ac) + DIM_W'(1);
   assign ar_n      = DIM_W'(ar) + DIM_W'(1);
   assign ec_n      = DIM_W'(ec_ff) + DIM_W'(1);
   assign cl        = (ec_ff != '0) ? ec_ff - COL_W'(1) : '0;
   assign cr        = (ec_n < w_eff) ? COL_W'(ec_n) : COL_W'(w_eff - DIM_W'(1));
   assign start     = (state_ff == T_READ) && (rc_ff == 3'd4);

   always_comb begin
      case (rc_ff)
         3'd0:    begin rbank = cb_ff; rcol = cl;    end
         3'd1:    begin rbank = cb_ff; rcol = cr;    end
         3'd2:    begin rbank = ub_ff; rcol = ec_ff; end
         default: begin rbank = db_ff; rcol = ec_ff; end
      endcase
   end

   assign wr_addr = ADDR_W'(eb0) * ADDR_W'(MAX_WIDTH) + ADDR_W'(ac);
   assign rd_addr = ADDR_W'(rbank) * ADDR_W'(MAX_WIDTH) + ADDR_W'(rcol);

   always_ff @(posedge clock) begin
      if (accept) mem[wr_addr] <= req_data;
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_FRAME_HEIGHT) ? {21'b0, fh_ff} : {21'b0, fw_ff};

   always_comb begin
      fw_in = fw_ff;
      fh_in = fh_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            CSR_FRAME_WIDTH:  fw_in = csr_pwdata[DIM_W-1:0];
            CSR_FRAME_HEIGHT: fh_in = csr_pwdata[DIM_W-1:0];
            default:          fw_in = fw_ff;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      b0_in    = b0_ff;
      b1_in    = b1_ff;
      b2_in    = b2_ff;
      ccol_in  = ccol_ff;
      crow_in  = crow_ff;
      sb0_in   = sb0_ff;
      sb1_in   = sb1_ff;
      sb2_in   = sb2_ff;
      pend_in  = pend_ff;
      ec_in    = ec_ff;
      er_in    = er_ff;
      cb_in    = cb_ff;
      ub_in    = ub_ff;
      db_in    = db_ff;
      last_in  = last_ff;
      rc_in    = rc_ff;
      nbr_in   = nbr_ff;
      rv_in    = rv_ff;
      rsp_in   = rsp_ff;

      case (state_ff)
         T_IDLE: begin
            if (accept) begin
               ccol_in    = ac;
               crow_in    = ar;
               sb0_in     = eb0;
               sb1_in     = b1_ff;
               sb2_in     = b2_ff;
               pend_in[0] = (ar != '0);
               pend_in[1] = (DIM_W'(ar) == h_eff - DIM_W'(1)) && (ac != '0);
               pend_in[2] = (DIM_W'(ar) == h_eff - DIM_W'(1)) &&
                            (DIM_W'(ac) == w_eff - DIM_W'(1));
               if (ac_n >= w_eff) begin
                  col_in = '0;
                  if (ar_n >= h_eff) begin
                     row_in = '0;
                     b0_in  = 2'd0;
                  end else begin
                     row_in = ROW_W'(ar_n);
                     b0_in  = (eb0 == 2'd2) ? 2'd0 : eb0 + 2'd1;
                     b1_in  = eb0;
                     b2_in  = b1_ff;
                  end
               end else begin
                  col_in = COL_W'(ac_n);
                  row_in = ar;
                  b0_in  = eb0;
               end
               state_in = T_NEXT;
            end
         end
         T_NEXT: begin
            rc_in = '0;
            if (pend_ff[0]) begin
               ec_in      = ccol_ff;
               er_in      = crow_ff - ROW_W'(1);
               cb_in      = sb1_ff;
               ub_in      = (crow_ff >= ROW_W'(2)) ? sb2_ff : sb1_ff;
               db_in      = sb0_ff;
               pend_in[0] = 1'b0;
               last_in    = !pend_ff[1] && !pend_ff[2];
               state_in   = T_READ;
            end else if (pend_ff[1]) begin
               ec_in      = ccol_ff - COL_W'(1);
               er_in      = crow_ff;
               cb_in      = sb0_ff;
               ub_in      = (crow_ff != '0) ? sb1_ff : sb0_ff;
               db_in      = sb0_ff;
               pend_in[1] = 1'b0;
               last_in    = !pend_ff[2];
               state_in   = T_READ;
            end else if (pend_ff[2]) begin
               ec_in      = ccol_ff;
               er_in      = crow_ff;
               cb_in      = sb0_ff;
               ub_in      = (crow_ff != '0) ? sb1_ff : sb0_ff;
               db_in      = sb0_ff;
               pend_in[2] = 1'b0;
               last_in    = 1'b1;
               state_in   = T_READ;
            end else begin
               state_in = T_IDLE;
            end
         end
         T_READ: begin
            case (rc_ff)
               3'd1:    nbr_in.l = rd_data_ff;
               3'd2:    nbr_in.r = rd_data_ff;
               3'd3:    nbr_in.u = rd_data_ff;
               3'd4:    nbr_in.d = rd_data_ff;
               default: nbr_in   = nbr_ff;
            endcase
            rc_in = rc_ff + 3'd1;
            if (rc_ff == 3'd4) state_in = T_RUN;
         end
         T_RUN: begin
            if (ustat.done) begin
               rsp_in.normal_x     = ures.nx;
               rsp_in.normal_y     = ures.ny;
               rsp_in.normal_z     = ures.nz;
               rsp_in.normal_valid = ures.valid;
               rsp_in.pixel_column = ec_ff;
               rsp_in.pixel_row    = er_ff;
               rsp_in.last_in_run  = last_ff;
               rv_in               = 1'b1;
               state_in            = T_OUT;
            end
         end
         T_OUT: begin
            if (!rsp_stall) begin
               rv_in    = 1'b0;
               state_in = T_NEXT;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         fw_ff    <= WIDTH_RESET;
         fh_ff    <= HEIGHT_RESET;
         col_ff   <= '0;
         row_ff   <= '0;
         b0_ff    <= '0;
         b1_ff    <= '0;
         b2_ff    <= '0;
         pend_ff  <= '0;
         rc_ff    <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         fw_ff    <= fw_in;
         fh_ff    <= fh_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         b0_ff    <= b0_in;
         b1_ff    <= b1_in;
         b2_ff    <= b2_in;
         pend_ff  <= pend_in;
         rc_ff    <= rc_in;
         rv_ff    <= rv_in;
      end
      ccol_ff <= ccol_in;
      crow_ff <= crow_in;
      sb0_ff  <= sb0_in;
      sb1_ff  <= sb1_in;
      sb2_ff  <= sb2_in;
      ec_ff   <= ec_in;
      er_ff   <= er_in;
      cb_ff   <= cb_in;
      ub_ff   <= ub_in;
      db_ff   <= db_in;
      last_ff <= last_in;
      nbr_ff  <= nbr_in;
      rsp_ff  <= rsp_in;
   end

   vmne_norm_unit u_norm (
      .clock (clock),
      .reset (reset),
      .start (start),
      .nbr   (nbr_in),
      .stat  (ustat),
      .res   (ures)
   );

   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- sv/vmne_norm_unit.sv -----
// ----------------------------------------------------------------------------
// vmne_norm_unit
// Sequenced cross product and normalization with one shared multiplier,
// a bit-serial square root and a bit-serial divider.
// ----------------------------------------------------------------------------
module vmne_norm_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  vmne_pkg::nbr_type nbr,
   output vmne_pkg::unit_stat_type stat,
   output vmne_pkg::norm_type res
);
   import vmne_pkg::*;

   typedef enum logic [9:0] {
      U_IDLE = 10'b0000000001,
      U_DIFF = 10'b0000000010,
      U_SH1  = 10'b0000000100,
      U_MUL  = 10'b0000001000,
      U_CHK  = 10'b0000010000,
      U_SH2  = 10'b0000100000,
      U_SQ   = 10'b0001000000,
      U_SQRT = 10'b0010000000,
      U_DIV  = 10'b0100000000,
      U_DONE = 10'b1000000000
   } ustate_type;

   ustate_type state_ff, state_in;
   logic [32:0] dm_ff [6];
   logic [32:0] dm_in [6];
   logic [5:0]  ds_ff, ds_in;
   logic signed [62:0] c_ff [3];
   logic signed [62:0] c_in [3];
   logic [61:0] cm_ff [3];
   logic [61:0] cm_in [3];
   logic [2:0]  cs_ff, cs_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic signed [61:0] prod_ff, prod_in;
   logic [61:0] sum_ff, sum_in;
   logic [61:0] rad_ff, rad_in;
   logic [33:0] rem_ff, rem_in;
   logic [30:0] root_ff, root_in;
   logic [5:0]  it_ff, it_in;
   logic [1:0]  comp_ff, comp_in;
   logic [44:0] num_ff, num_in;
   logic [31:0] remd_ff, remd_in;
   logic [14:0] quo_ff, quo_in;
   norm_type    res_ff, res_in;

   logic signed [30:0] mul_a, mul_b;
   logic [32:0] dor;
   logic [61:0] cor;
   logic signed [32:0] dv [6];
   logic [33:0] rem_t;
   logic [32:0] trial;
   logic [31:0] dt;
   logic        qb;
   logic [14:0] qf;
   logic signed [15:0] qs;
   logic [2:0]  j;

   function automatic logic signed [30:0] sval(logic [32:0] m, logic s);
      logic signed [30:0] v;
      v = $signed({1'b0, m[29:0]});
      return s ? -v : v;
   endfunction

   function automatic logic [44:0] numer(logic [61:0] m, logic [30:0] n);
      return {1'b0, m[29:0], 14'b0} + {15'b0, n[30:1]};
   endfunction

   always_comb begin
      dv[0] = $signed({nbr.r.vertex_x[31], nbr.r.vertex_x})
            - $signed({nbr.l.vertex_x[31], nbr.l.vertex_x});
      dv[1] = $signed({nbr.r.vertex_y[31], nbr.r.vertex_y})
            - $signed({nbr.l.vertex_y[31], nbr.l.vertex_y});
      dv[2] = $signed({nbr.r.vertex_z[31], nbr.r.vertex_z})
            - $signed({nbr.l.vertex_z[31], nbr.l.vertex_z});
      dv[3] = $signed({nbr.d.vertex_x[31], nbr.d.vertex_x})
            - $signed({nbr.u.vertex_x[31], nbr.u.vertex_x});
      dv[4] = $signed({nbr.d.vertex_y[31], nbr.d.vertex_y})
            - $signed({nbr.u.vertex_y[31], nbr.u.vertex_y});
      dv[5] = $signed({nbr.d.vertex_z[31], nbr.d.vertex_z})
            - $signed({nbr.u.vertex_z[31], nbr.u.vertex_z});
   end

   // multiplier operand select: cross terms, then squares
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == U_SQ) begin
         mul_a = $signed({1'b0, cm_ff[cnt_ff[1:0]][29:0]});
         mul_b = mul_a;
      end else begin
         case (cnt_ff)
            3'd0: begin mul_a = sval(dm_ff[4], ds_ff[4]); mul_b = sval(dm_ff[2], ds_ff[2]); end
            3'd1: begin mul_a = sval(dm_ff[5], ds_ff[5]); mul_b = sval(dm_ff[1], ds_ff[1]); end
            3'd2: begin mul_a = sval(dm_ff[5], ds_ff[5]); mul_b = sval(dm_ff[0], ds_ff[0]); end
            3'd3: begin mul_a = sval(dm_ff[3], ds_ff[3]); mul_b = sval(dm_ff[2], ds_ff[2]); end
            3'd4: begin mul_a = sval(dm_ff[3], ds_ff[3]); mul_b = sval(dm_ff[1], ds_ff[1]); end
            3'd5: begin mul_a = sval(dm_ff[4], ds_ff[4]); mul_b = sval(dm_ff[0], ds_ff[0]); end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      dm_in    = dm_ff;
      ds_in    = ds_ff;
      c_in     = c_ff;
      cm_in    = cm_ff;
      cs_in    = cs_ff;
      cnt_in   = cnt_ff;
      prod_in  = prod_ff;
      sum_in   = sum_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      it_in    = it_ff;
      comp_in  = comp_ff;
      num_in   = num_ff;
      remd_in  = remd_ff;
      quo_in   = quo_ff;
      res_in   = res_ff;
      dor      = dm_ff[0] | dm_ff[1] | dm_ff[2] | dm_ff[3] | dm_ff[4] | dm_ff[5];
      cor      = cm_ff[0] | cm_ff[1] | cm_ff[2];
      j        = cnt_ff - 3'd1;
      rem_t    = {rem_ff[31:0], rad_ff[61:60]};
      trial    = {root_ff, 2'b01};
      dt       = {remd_ff[30:0], num_ff[44]};
      qb       = dt >= {1'b0, root_ff};
      qf       = {quo_ff[13:0], qb};
      qs       = $signed({1'b0, qf});
      if (cs_ff[comp_ff]) qs = -qs;

      case (state_ff)
         U_IDLE: begin
            if (start) begin
               res_in   = '0;
               state_in = U_DIFF;
            end
         end
         U_DIFF: begin
            for (int i = 0; i < 6; i++) begin
               ds_in[i] = dv[i][32];
               dm_in[i] = dv[i][32] ? 33'(-dv[i]) : 33'(dv[i]);
            end
            if (nbr.l.vertex_z == 0 || nbr.r.vertex_z == 0 ||
                nbr.u.vertex_z == 0 || nbr.d.vertex_z == 0) begin
               state_in = U_DONE;
            end else begin
               state_in = U_SH1;
            end
         end
         U_SH1: begin
            if (dor[32:30] != 3'b0) begin
               for (int i = 0; i < 6; i++) dm_in[i] = dm_ff[i] >> 1;
            end else begin
               cnt_in   = '0;
               state_in = U_MUL;
            end
         end
         U_MUL: begin
            if (cnt_ff < 3'd6) prod_in = mul_a * mul_b;
            if (cnt_ff != 3'd0) begin
               if (!j[0]) c_in[j[2:1]] = 63'(prod_ff);
               else       c_in[j[2:1]] = c_ff[j[2:1]] - 63'(prod_ff);
            end
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd6) state_in = U_CHK;
         end
         U_CHK: begin
            for (int i = 0; i < 3; i++) begin
               cs_in[i] = c_ff[i][62];
               cm_in[i] = c_ff[i][62] ? 62'(-c_ff[i]) : 62'(c_ff[i]);
            end
            sum_in = '0;
            if (c_ff[0] == 0 && c_ff[1] == 0 && c_ff[2] == 0) state_in = U_DONE;
            else                                              state_in = U_SH2;
         end
         U_SH2: begin
            if (cor[61:30] != 32'b0) begin
               for (int i = 0; i < 3; i++) cm_in[i] = cm_ff[i] >> 1;
            end else begin
               cnt_in   = '0;
               state_in = U_SQ;
            end
         end
         U_SQ: begin
            if (cnt_ff < 3'd3) prod_in = mul_a * mul_b;
            if (cnt_ff != 3'd0) sum_in = sum_ff + 62'(prod_ff);
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd3) begin
               rad_in   = sum_in;
               rem_in   = '0;
               root_in  = '0;
               it_in    = '0;
               state_in = U_SQRT;
            end
         end
         U_SQRT: begin
            if (rem_t >= {1'b0, trial}) begin
               rem_in  = rem_t - {1'b0, trial};
               root_in = {root_ff[29:0], 1'b1};
            end else begin
               rem_in  = rem_t;
               root_in = {root_ff[29:0], 1'b0};
            end
            rad_in = rad_ff << 2;
            it_in  = it_ff + 6'd1;
            if (it_ff == 6'd30) begin
               comp_in  = '0;
               num_in   = numer(cm_ff[0], root_in);
               remd_in  = '0;
               quo_in   = '0;
               it_in    = '0;
               state_in = U_DIV;
            end
         end
         U_DIV: begin
            remd_in = qb ? dt - {1'b0, root_ff} : dt;
            quo_in  = qf;
            num_in  = num_ff << 1;
            it_in   = it_ff + 6'd1;
            if (it_ff == 6'd44) begin
               case (comp_ff)
                  2'd0:    res_in.nx = qs;
                  2'd1:    res_in.ny = qs;
                  default: res_in.nz = qs;
               endcase
               it_in   = '0;
               remd_in = '0;
               quo_in  = '0;
               comp_in = comp_ff + 2'd1;
               if (comp_ff == 2'd2) begin
                  res_in.valid = 1'b1;
                  state_in     = U_DONE;
               end else begin
                  num_in = numer(cm_ff[comp_ff + 2'd1], root_ff);
               end
            end
         end
         U_DONE: begin
            state_in = U_IDLE;
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
      end else begin
         state_ff <= state_in;
      end
      dm_ff   <= dm_in;
      ds_ff   <= ds_in;
      c_ff    <= c_in;
      cm_ff   <= cm_in;
      cs_ff   <= cs_in;
      cnt_ff  <= cnt_in;
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      it_ff   <= it_in;
      comp_ff <= comp_in;
      num_ff  <= num_in;
      remd_ff <= remd_in;
      quo_ff  <= quo_in;
      res_ff  <= res_in;
   end

   assign stat.done = (state_ff == U_DONE);
   assign stat.busy = (state_ff != U_IDLE);
   assign res       = res_ff;

endmodule

// ----- tb/vmne_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmne_checker
// Watches the request, result and register ports of the normal estimator,
// predicts every result from the accepted vertices and compares in order.
// ----------------------------------------------------------------------------
module vmne_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  vmne_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  vmne_pkg::rsp_type rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   input  logic              csr_pready,
   output int                errors,
   output int                pending
);
   import vmne_pkg::*;

   req_type          vertex_rows [3][MAX_WIDTH];
   rsp_type          normals_due [$];
   logic [DIM_W-1:0] width_reg;
   logic [DIM_W-1:0] height_reg;
   int               next_col;
   int               next_row;

   function automatic longint unsigned mag(longint v);
      return (v < 0) ? longint'(-v) : v;
   endfunction

   function automatic longint shr_tz(longint v, int s);
      longint unsigned m;
      m = mag(v) >> s;
      return (v < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic int fit_shift(longint unsigned m);
      int s;
      s = 0;
      while ((m >> s) >= (64'd1 << 30)) s++;
      return s;
   endfunction

   function automatic longint unsigned isqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic rsp_type normal_at(int col, int row, int w, int h);
      req_type         lv, rv, uv, dv;
      longint          dx [3];
      longint          dy [3];
      longint          c [3];
      longint unsigned m, sum, n, q;
      logic [15:0]     comp [3];
      int              s;
      rsp_type         o;
      o = '0;
      o.pixel_column = COL_W'(col);
      o.pixel_row = ROW_W'(row);
      lv = vertex_rows[row % 3][(col > 0) ? col - 1 : 0];
      rv = vertex_rows[row % 3][(col + 1 < w) ? col + 1 : w - 1];
      uv = vertex_rows[((row > 0) ? row - 1 : 0) % 3][col];
      dv = vertex_rows[((row + 1 < h) ? row + 1 : h - 1) % 3][col];
      if (lv.vertex_z == 0 || rv.vertex_z == 0 || uv.vertex_z == 0 || dv.vertex_z == 0)
         return o;
      dx[0] = longint'(rv.vertex_x) - longint'(lv.vertex_x);
      dx[1] = longint'(rv.vertex_y) - longint'(lv.vertex_y);
      dx[2] = longint'(rv.vertex_z) - longint'(lv.vertex_z);
      dy[0] = longint'(dv.vertex_x) - longint'(uv.vertex_x);
      dy[1] = longint'(dv.vertex_y) - longint'(uv.vertex_y);
      dy[2] = longint'(dv.vertex_z) - longint'(uv.vertex_z);
      m = 0;
      for (int i = 0; i < 3; i++) begin
         if (mag(dx[i]) > m) m = mag(dx[i]);
         if (mag(dy[i]) > m) m = mag(dy[i]);
      end
      s = fit_shift(m);
      for (int i = 0; i < 3; i++) begin
         dx[i] = shr_tz(dx[i], s);
         dy[i] = shr_tz(dy[i], s);
      end
      c[0] = dy[1] * dx[2] - dy[2] * dx[1];
      c[1] = dy[2] * dx[0] - dy[0] * dx[2];
      c[2] = dy[0] * dx[1] - dy[1] * dx[0];
      if (c[0] == 0 && c[1] == 0 && c[2] == 0) return o;
      m = 0;
      for (int i = 0; i < 3; i++)
         if (mag(c[i]) > m) m = mag(c[i]);
      s = fit_shift(m);
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         c[i] = shr_tz(c[i], s);
         sum = sum + mag(c[i]) * mag(c[i]);
      end
      n = isqrt(sum);
      if (n == 0) return o;
      for (int i = 0; i < 3; i++) begin
         q = (mag(c[i]) * 16384 + n / 2) / n;
         comp[i] = (c[i] < 0) ? 16'(-longint'(q)) : 16'(q);
      end
      o.normal_x = comp[0];
      o.normal_y = comp[1];
      o.normal_z = comp[2];
      o.normal_valid = 1'b1;
      return o;
   endfunction

   task automatic take_vertex(req_type v);
      int      w, h, col, row, k;
      rsp_type res [3];
      w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
      h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
      if (next_col >= w || next_row >= h) begin
         next_col = 0;
         next_row = 0;
      end
      col = next_col;
      row = next_row;
      vertex_rows[row % 3][col] = v;
      k = 0;
      if (row >= 1) begin
         res[k] = normal_at(col, row - 1, w, h);
         k = k + 1;
      end
      if (row == h - 1) begin
         if (col >= 1) begin
            res[k] = normal_at(col - 1, row, w, h);
            k = k + 1;
         end
         if (col == w - 1) begin
            res[k] = normal_at(col, row, w, h);
            k = k + 1;
         end
      end
      if (k > 0) res[k-1].last_in_run = 1'b1;
      for (int i = 0; i < k; i++) normals_due.push_back(res[i]);
      next_col = col + 1;
      if (next_col >= w) begin
         next_col = 0;
         next_row = row + 1;
         if (next_row >= h) next_row = 0;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         normals_due.delete();
         width_reg = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         next_col = 0;
         next_row = 0;
         errors = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == CSR_FRAME_WIDTH) width_reg = csr_pwdata[DIM_W-1:0];
            else height_reg = csr_pwdata[DIM_W-1:0];
         end
         if (rsp_valid && !rsp_stall) begin
            if (normals_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected result %p", $time, rsp_data);
            end else begin
               want = normals_due.pop_front();
               if (rsp_data !== want) begin
                  errors++;
                  $display("%0t: mismatch expected %p actual %p", $time, want, rsp_data);
               end
            end
         end
         if (req_valid && !req_stall) take_vertex(req_data);
      end
      pending = normals_due.size();
   end

endmodule

// ----- tb/tb_vertex_map_normal_estimator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vertex_map_normal_estimator_core
// Drives vertex frames of many sizes through the normal estimator, with
// random gaps on both channels and long result hold-offs in the last stage.
// ----------------------------------------------------------------------------
module tb_vertex_map_normal_estimator_core;
   import vmne_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          errors;
   int          pending;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          hold_cycles;
   longint      cycles;

   vertex_map_normal_estimator_core uut (.*);

   vmne_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 3000000) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles--;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   task automatic csr_write(logic idx, int value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_frame(int w, int h);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      csr_write(CSR_FRAME_WIDTH, w);
      csr_write(CSR_FRAME_HEIGHT, h);
   endtask

   task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= {x, y, z};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_frame(int w, int h, int n);
      int          mode, k;
      logic [31:0] z;
      mode = $urandom_range(0, 3);
      k = 0;
      for (int r = 0; r < h; r++) begin
         for (int c = 0; c < w; c++) begin
            if (k >= n) return;
            k++;
            if (mode == 0) begin
               send_vertex($urandom, $urandom, ($urandom_range(0, 15) == 0) ? 0 : $urandom);
            end else begin
               z = 32'sd65536 + $urandom_range(0, 1 << 18) - (1 << 17);
               if ($urandom_range(0, 19) == 0) z = 0;
               send_vertex((c << 14) + $urandom_range(0, 255), (r << 14) - $urandom_range(0, 255),
                           (mode == 3) ? 32'sd65536 : z);
            end
         end
      end
   endtask

   initial begin
      int w, h, sent;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      send_idle_pct = 30;
      recv_idle_pct = 79;
      hold_cycles = 0;
      cycles = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // 3x3: field extremes, missing depth, huge differences
      set_frame(3, 3);
      send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_vertex(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
      send_vertex(32'h0001_0000, 32'h0001_0000, 32'h0000_0000);
      send_vertex(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001);
      send_vertex(32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000);
      send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_vertex(32'h8000_0000, 32'h8000_0000, 32'h0001_0000);
      send_vertex(32'hAAAA_AAAA, 32'h5555_5555, 32'h7FFF_FFFF);
      // out-of-range zero registers act as a single pixel
      set_frame(0, 0);
      send_vertex(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
      // flat tile, equal points give a degenerate product
      set_frame(4, 2);
      for (int i = 0; i < 8; i++) send_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      // oversize width acts as the maximum, single row
      set_frame(2047, 1);
      send_frame(MAX_WIDTH, 1, 8);
      // maximum height, abandoned mid-frame by shrinking the height
      set_frame(2, 1024);
      send_frame(2, 3, 6);
      set_frame(2, 3);
      send_frame(2, 3, 6);
      set_frame(1024, 2047);
      send_frame(1024, 1, 3);
      set_frame(3, 2);
      send_frame(3, 2, 6);

      sent = 0;
      for (int stage = 0; stage < 3; stage++) begin
         send_idle_pct = (stage == 0) ? 30 : (stage == 1) ? 79 : 0;
         recv_idle_pct = (stage == 0) ? 79 : (stage == 1) ? 30 : 0;
         while (sent < 141 * (stage + 1)) begin
            w = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 8);
            h = $urandom_range(1, 6);
            set_frame(w, h);
            if (stage == 2 && hold_cycles == 0 && sent < 340) hold_cycles = 4000;
            send_frame(w, h, w * h);
            sent += w * h;
         end
      end
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
